// ===== rtl/core/rgb_to_yuv420_converter_defines.svh =====
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter - assertion macros
// Shared property forms for the stream-side checks.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_DEFINES_SVH

// ante |-> cons, sampled on the rising clock edge, off during reset
`define R2Y_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// sig holds its value over a stalled beat
`define R2Y_ASSERT_HOLD(label, clk, rst, vld, rdy, sig) \
   label: assert property (@(posedge clk) disable iff (rst) (vld && !rdy) |=> $stable(sig)) \
      else $error("assertion failed: stalled beat changed");

`endif

// ===== rtl/core/rgb2yuv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Constants, coefficients and helper functions of the RGB to YUV 4:2:0 block.
// ----------------------------------------------------------------------------
package rgb2yuv_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 4096;
   localparam int unsigned DEF_MAX_HEIGHT = 4096;

   localparam int unsigned PIX_W      = 8;
   localparam int unsigned REQ_DATA_W = 3 * PIX_W;
   localparam int unsigned RSP_DATA_W = 3 * PIX_W;
   localparam int unsigned CSR_W      = 13;
   localparam int unsigned CSR_ADDR_W = 1;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // Q0.16 coefficients
   localparam int unsigned COEF_W = 16;
   localparam int unsigned PROD_W = COEF_W + PIX_W;
   localparam int unsigned ACC_W  = PROD_W + 3;

   localparam logic [COEF_W-1:0] COEF_Y_R = 16'd19595;
   localparam logic [COEF_W-1:0] COEF_Y_G = 16'd38470;
   localparam logic [COEF_W-1:0] COEF_Y_B = 16'd7471;
   localparam logic [COEF_W-1:0] COEF_U_R = 16'd11036;
   localparam logic [COEF_W-1:0] COEF_U_G = 16'd21732;
   localparam logic [COEF_W-1:0] COEF_V_G = 16'd27440;
   localparam logic [COEF_W-1:0] COEF_V_B = 16'd5328;

   localparam logic [PIX_W:0] CHROMA_OFFSET = 9'd128;

   // clamp to 2..maxv, then round down to even
   function automatic logic [31:0] eff_size(input logic [CSR_W-1:0] v,
                                            input logic [31:0] maxv);
      logic [31:0] s;
      s = {{(32 - CSR_W){1'b0}}, v};
      if (s < 32'd2) s = 32'd2;
      if (s > maxv) s = maxv;
      return s & ~32'd1;
   endfunction

   // drop 16 fraction bits, saturate to 0..255
   function automatic logic [PIX_W-1:0] sat_q16(input logic signed [ACC_W-1:0] acc);
      logic [ACC_W-COEF_W-1:0] ip;
      logic [PIX_W-1:0]        res;
      ip = acc[ACC_W-1:COEF_W];
      if (acc[ACC_W-1]) res = '0;
      else if (ip > (ACC_W-COEF_W)'(255)) res = '1;
      else res = ip[PIX_W-1:0];
      return res;
   endfunction

endpackage

// ===== rtl/core/rgb2yuv_csc.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_csc
// Two-stage colour space conversion: constant multiplies, then sum and clip.
// ----------------------------------------------------------------------------
module rgb2yuv_csc (
   input  logic                           clock,
   input  logic                           en,
   input  logic [rgb2yuv_pkg::PIX_W-1:0]  red,
   input  logic [rgb2yuv_pkg::PIX_W-1:0]  green,
   input  logic [rgb2yuv_pkg::PIX_W-1:0]  blue,
   output logic [rgb2yuv_pkg::PIX_W-1:0]  luma,
   output logic [rgb2yuv_pkg::PIX_W-1:0]  chroma_u,
   output logic [rgb2yuv_pkg::PIX_W-1:0]  chroma_v
);
   import rgb2yuv_pkg::*;

   logic [PROD_W-1:0] y_r_ff, y_g_ff, y_b_ff;
   logic [PROD_W-1:0] u_r_ff, u_g_ff, v_g_ff, v_b_ff;
   logic [PIX_W:0]    u_base_ff, v_base_ff;

   logic signed [ACC_W-1:0] y_acc, u_acc, v_acc;
   logic [PIX_W-1:0]        luma_ff, u_ff, v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         y_r_ff    <= PROD_W'(red)   * PROD_W'(COEF_Y_R);
         y_g_ff    <= PROD_W'(green) * PROD_W'(COEF_Y_G);
         y_b_ff    <= PROD_W'(blue)  * PROD_W'(COEF_Y_B);
         u_r_ff    <= PROD_W'(red)   * PROD_W'(COEF_U_R);
         u_g_ff    <= PROD_W'(green) * PROD_W'(COEF_U_G);
         v_g_ff    <= PROD_W'(green) * PROD_W'(COEF_V_G);
         v_b_ff    <= PROD_W'(blue)  * PROD_W'(COEF_V_B);
         u_base_ff <= (PIX_W + 1)'(blue >> 1) + CHROMA_OFFSET;
         v_base_ff <= (PIX_W + 1)'(red >> 1) + CHROMA_OFFSET;
      end
   end

   always_comb begin
      y_acc = $signed({3'b000, y_r_ff}) + $signed({3'b000, y_g_ff})
            + $signed({3'b000, y_b_ff});
      u_acc = $signed({2'b00, u_base_ff, {COEF_W{1'b0}}})
            - $signed({3'b000, u_r_ff}) - $signed({3'b000, u_g_ff});
      v_acc = $signed({2'b00, v_base_ff, {COEF_W{1'b0}}})
            - $signed({3'b000, v_g_ff}) - $signed({3'b000, v_b_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         luma_ff <= sat_q16(y_acc);
         u_ff    <= sat_q16(u_acc);
         v_ff    <= sat_q16(v_acc);
      end
   end

   assign luma     = luma_ff;
   assign chroma_u = u_ff;
   assign chroma_v = v_ff;

endmodule

// ===== rtl/core/rgb_to_yuv420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// Raster RGB in, per-pixel luma and 2x2-averaged chroma out (BT.601, Q0.16).
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one beat per pixel through stages s1,
// s2 and s3; the only stall source is rsp_tready, which holds the whole pipe.
// Horizontal chroma pair sums of even lines live in a single-port-write,
// one-read line store of MAX_WIDTH/2 entries; the odd line reads them back a
// line later, so no read can overtake its write. The store needs no clearing
// pass after reset. Sizes must be written on the csr port while no beat is in
// flight, not enforced by the block; the raster position is kept across a size change.
module rgb_to_yuv420_converter #(
   parameter int unsigned MAX_WIDTH  = rgb2yuv_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = rgb2yuv_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rgb2yuv_pkg::REQ_DATA_W-1:0]  req_tdata,   // red, green, blue
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rgb2yuv_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // luma, chroma_blue, chroma_red
   output logic                                rsp_tuser,   // chroma_valid
   output logic                                rsp_tlast,   // frame_end
   input  logic                                csr_wen,
   input  logic [rgb2yuv_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rgb2yuv_pkg::CSR_W-1:0]       csr_wdata
);
   import rgb2yuv_pkg::*;

   localparam int unsigned COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned WSIZE_W    = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HSIZE_W    = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
   localparam int unsigned IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int unsigned SUM_W      = PIX_W + 1;

   typedef struct packed {
      logic odd_col;
      logic odd_row;
      logic frame_end;
   } pix_tag_type;

   // sizes
   logic [WSIZE_W-1:0] width_ff;
   logic [HSIZE_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WSIZE_W'(eff_size(CSR_W'(1280), 32'(MAX_WIDTH)));
         height_ff <= HSIZE_W'(eff_size(CSR_W'(720), 32'(MAX_HEIGHT)));
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  width_ff  <= WSIZE_W'(eff_size(csr_wdata, 32'(MAX_WIDTH)));
            CSR_FRAME_HEIGHT: height_ff <= HSIZE_W'(eff_size(csr_wdata, 32'(MAX_HEIGHT)));
            default: ;
         endcase
      end
   end

   // pipe control
   logic en, accept;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;

   assign en         = !s3_valid_ff || rsp_tready;
   assign accept     = req_tvalid && en;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // raster position
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [WSIZE_W-1:0] col_inc;
   logic [HSIZE_W-1:0] row_inc;
   logic               last_col, last_row;

   always_comb begin
      col_inc  = WSIZE_W'(col_ff) + WSIZE_W'(1);
      row_inc  = HSIZE_W'(row_ff) + HSIZE_W'(1);
      last_col = col_inc >= width_ff;
      last_row = row_inc >= height_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : ROW_W'(row_inc);
         end else begin
            col_in = COL_W'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // tags
   pix_tag_type      tag1_ff, tag2_ff;
   logic [IDX_W-1:0] idx1_ff, idx2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         tag1_ff <= '{odd_col: col_ff[0], odd_row: row_ff[0],
                      frame_end: last_col && last_row};
         idx1_ff <= IDX_W'(col_ff >> 1);
         tag2_ff <= tag1_ff;
         idx2_ff <= idx1_ff;
      end
   end

   // colour conversion, results line up with stage 2
   logic [PIX_W-1:0] luma2, u2, v2;

   rgb2yuv_csc u_csc (
      .clock    (clock),
      .en       (en),
      .red      (req_tdata[PIX_W-1:0]),
      .green    (req_tdata[2*PIX_W-1:PIX_W]),
      .blue     (req_tdata[3*PIX_W-1:2*PIX_W]),
      .luma     (luma2),
      .chroma_u (u2),
      .chroma_v (v2)
   );

   // left pixel of the pair
   logic [2*PIX_W-1:0] left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (en && s2_valid_ff && !tag2_ff.odd_col) begin
         left_ff <= {v2, u2};
      end
   end

   logic [SUM_W-1:0] su, sv;

   assign su = SUM_W'(left_ff[PIX_W-1:0]) + SUM_W'(u2);
   assign sv = SUM_W'(left_ff[2*PIX_W-1:PIX_W]) + SUM_W'(v2);

   // pair-sum line store: read on entry to stage 2, written on exit
   logic [2*SUM_W-1:0] line_mem [LINE_DEPTH];
   logic [2*SUM_W-1:0] line_rd_ff;
   logic               line_wr;

   assign line_wr = en && s2_valid_ff && tag2_ff.odd_col && !tag2_ff.odd_row;

   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_mem[idx2_ff] <= {sv, su};
      end
      if (en) begin
         line_rd_ff <= line_mem[idx1_ff];
      end
   end

   // 2x2 average
   logic [SUM_W:0]   quad_u, quad_v;
   logic             cvalid_in;
   logic [PIX_W-1:0] cb_in, cr_in;

   always_comb begin
      quad_u    = (SUM_W + 1)'(line_rd_ff[SUM_W-1:0]) + (SUM_W + 1)'(su);
      quad_v    = (SUM_W + 1)'(line_rd_ff[2*SUM_W-1:SUM_W]) + (SUM_W + 1)'(sv);
      cvalid_in = tag2_ff.odd_col && tag2_ff.odd_row;
      cb_in     = cvalid_in ? quad_u[SUM_W:2] : '0;
      cr_in     = cvalid_in ? quad_v[SUM_W:2] : '0;
   end

   // output register
   logic [PIX_W-1:0] luma_ff, cb_ff, cr_ff;
   logic             cvalid_ff, last_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         luma_ff   <= luma2;
         cb_ff     <= cb_in;
         cr_ff     <= cr_in;
         cvalid_ff <= cvalid_in;
         last_ff   <= tag2_ff.frame_end;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {cr_ff, cb_ff, luma_ff};
   assign rsp_tuser  = cvalid_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== rtl/core/rgb2yuv_checker.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_checker
// Port-level checks of the converter's stream behaviour, bound to the top.
// ----------------------------------------------------------------------------
`include "rgb_to_yuv420_converter_defines.svh"

module rgb2yuv_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rgb2yuv_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);
   import rgb2yuv_pkg::*;

   logic [RSP_DATA_W+1:0]       rsp_beat;
   logic [RSP_DATA_W-PIX_W-1:0] rsp_chroma;

   assign rsp_beat   = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign rsp_chroma = rsp_tdata[RSP_DATA_W-1:PIX_W];

   // result beat held while stalled
   `R2Y_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_tvalid, rsp_tready, rsp_beat)

   // empty output stage never back-pressures the input
   `R2Y_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // stalled output stalls the input
   `R2Y_ASSERT_IMPLIES(a_stall_propagates, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

   // chroma fields are zero on beats without chroma
   `R2Y_ASSERT_IMPLIES(a_chroma_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_chroma == '0)

endmodule

bind rgb_to_yuv420_converter rgb2yuv_checker u_checker (.*);
